@@ rtl/core/bcdu_pkg.sv @@
// Package for the BCD add/subtract/multiply unit.
// Holds mode and status codes and the stage control type; no dependencies.
package bcdu_pkg;

    localparam int FIELD_W = 40;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NEG     = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_ZERO    = 2'd3
    } status_t;

    // Stage control travelling with each item.
    typedef struct packed {
        logic  [1:0] mode;
        status_t     status;
    } stage_ctl_t;

endpackage

@@ rtl/core/bcdu_stream_if.sv @@
// Valid/ready stream interface carrying a parameterized payload.
// Depends on nothing.
interface bcdu_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/bcd_add_sub_mul_unit_top.sv @@
// Top level of the BCD add/subtract/multiply unit.
// Depends on bcdu_pkg and bcdu_stream_if.
//
// The unit takes one transfer per cycle unless stalled and returns one
// result for each, in order, through the pipeline stages described below.
// Stage 0 checks digits and the sign of a subtraction and registers the
// operands; operands of a refused item are cleared there. Then DIGITS row
// stages follow. For add and subtract, row stage i forms result digit i and
// passes a one-bit carry or borrow to the next stage. For multiply, row stage
// i adds operand_a digit i times every digit of operand_b into a carry-save
// decimal accumulator (one digit plus a two-bit carry per position), so no
// carry ripples inside a row stage. Two normalize stages then fold the
// carries: the first absorbs the two-bit carries and leaves one-bit carries,
// the second resolves those with a generate/propagate chain. A last stage
// registers the result halves and status. A global stall freezes every stage
// while the output register holds an untaken result, so nothing is lost or
// repeated; ready is high whenever the output register is empty or taken.
// Input payload: {mode[1:0], operand_b, operand_a}; output payload:
// {status[1:0], result_high, result_low}.
module bcd_add_sub_mul_unit_top #(
    parameter int DIGITS = 10
) (
    input logic clk,
    input logic rst_n,
    bcdu_stream_if.sink   in_ch,
    bcdu_stream_if.source out_ch
);
    import bcdu_pkg::*;

    localparam int DW = 4 * DIGITS;
    localparam int PW = 8 * DIGITS;
    localparam int CW = 4 * DIGITS;
    localparam int NS = DIGITS + 1;
    localparam int NT = DIGITS + 3;

    // Tens digit of a product of two decimal digits (at most 81).
    function automatic logic [3:0] tens_of(logic [6:0] p);
        logic [14:0] r;
        r = 15'(p) * 15'd205;
        return r[14:11];
    endfunction

    logic advance;
    assign advance = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;

    logic [1:0]          in_mode;
    logic [FIELD_W-1:0]  in_a, in_b;
    assign in_a    = in_ch.data[FIELD_W-1:0];
    assign in_b    = in_ch.data[2*FIELD_W-1:FIELD_W];
    assign in_mode = in_ch.data[2*FIELD_W+1:2*FIELD_W];

    // Valid bits for stage 0, the row stages and the two normalize stages.
    logic [NT-1:0]  v_reg;
    // Row pipeline: index s holds the item after s row steps.
    stage_ctl_t     ctl_reg [NS];
    logic [DW-1:0]  a_reg   [DIGITS];
    logic [DW-1:0]  b_reg   [DIGITS];
    logic           cy_reg  [DIGITS];
    logic [PW-1:0]  acc_reg [NS];
    logic [CW-1:0]  cv_reg  [NS];
    logic [PW-1:0]  acc_next [DIGITS];
    logic [CW-1:0]  cv_next  [DIGITS];
    logic           cy_next  [DIGITS];

    // Stage 0 checks.
    logic [DW-1:0] a0, b0;
    logic          bad, lt, ok0;
    stage_ctl_t    ctl0;
    assign a0 = DW'(in_a);
    assign b0 = DW'(in_b);

    always_comb
    begin
        bad = 1'b0;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (a0[4*k +: 4] > 4'd9 || b0[4*k +: 4] > 4'd9)
                bad = 1'b1;
        end
        lt = (a0 < b0);
        ctl0.mode = in_mode;
        priority if (in_mode == MODE_NOP)
            ctl0.status = STAT_ZERO;
        else if (bad)
            ctl0.status = STAT_INVALID;
        else if (in_mode == MODE_SUB && lt)
            ctl0.status = STAT_NEG;
        else
            ctl0.status = STAT_OK;
    end

    assign ok0 = (ctl0.status == STAT_OK);

    // Row stages.
    always_comb
    begin
        logic [3:0] ad, bd;
        logic [4:0] t;
        logic [4:0] sum;
        logic [6:0] pr;
        logic [3:0] q;
        logic [6:0] u7;
        logic [3:0] lo_d [DIGITS];
        logic [3:0] hi_d [DIGITS];
        logic [3:0] lo, hi, dig;
        logic [1:0] c, c_prev;
        for (int s = 0; s < DIGITS; s++)
        begin
            ad = a_reg[s][4*s +: 4];
            bd = b_reg[s][4*s +: 4];
            acc_next[s] = acc_reg[s];
            cv_next[s]  = cv_reg[s];
            cy_next[s]  = 1'b0;
            t      = '0;
            sum    = '0;
            lo     = '0;
            hi     = '0;
            dig    = '0;
            c      = '0;
            c_prev = '0;
            // Units and tens of each digit product of this row.
            for (int k = 0; k < DIGITS; k++)
            begin
                pr = {3'd0, ad} * {3'd0, b_reg[s][4*k +: 4]};
                q  = tens_of(pr);
                u7 = pr - ({3'd0, q} * 7'd10);
                lo_d[k] = u7[3:0];
                hi_d[k] = q;
            end
            unique case (ctl_reg[s].mode)
                MODE_ADD:
                begin
                    t = {1'b0, ad} + {1'b0, bd} + {4'd0, cy_reg[s]};
                    if (t > 5'd9)
                    begin
                        acc_next[s][4*s +: 4] = 4'(t - 5'd10);
                        cy_next[s] = 1'b1;
                    end
                    else
                        acc_next[s][4*s +: 4] = t[3:0];
                    if (s == DIGITS - 1)
                        acc_next[s][4*DIGITS +: 4] = {3'd0, cy_next[s]};
                end
                MODE_SUB:
                begin
                    t = {1'b0, bd} + {4'd0, cy_reg[s]};
                    if ({1'b0, ad} < t)
                    begin
                        acc_next[s][4*s +: 4] = 4'({1'b0, ad} + 5'd10 - t);
                        cy_next[s] = 1'b1;
                    end
                    else
                        acc_next[s][4*s +: 4] = 4'({1'b0, ad} - t);
                end
                MODE_MUL:
                begin
                    // Each position takes its old digit, its saved carry, the
                    // units of one product and the tens of the one below.
                    for (int p = 0; p < 2*DIGITS; p++)
                    begin
                        lo = '0;
                        hi = '0;
                        if (p >= s && p < s + DIGITS)
                            lo = lo_d[p - s];
                        if (p >= s + 1 && p <= s + DIGITS)
                            hi = hi_d[p - s - 1];
                        sum = {1'b0, acc_reg[s][4*p +: 4]} + {3'd0, cv_reg[s][2*p +: 2]}
                            + {1'b0, lo} + {1'b0, hi};
                        if (sum >= 5'd20)
                        begin
                            dig = 4'(sum - 5'd20);
                            c   = 2'd2;
                        end
                        else if (sum >= 5'd10)
                        begin
                            dig = 4'(sum - 5'd10);
                            c   = 2'd1;
                        end
                        else
                        begin
                            dig = sum[3:0];
                            c   = 2'd0;
                        end
                        acc_next[s][4*p +: 4] = dig;
                        cv_next[s][2*p +: 2]  = c_prev;
                        c_prev = c;
                    end
                end
                default:
                begin
                    acc_next[s] = acc_reg[s];
                end
            endcase
        end
    end

    // First normalize stage: fold the two-bit carries into the digits.
    logic [PW-1:0]         n1_dig_next, n1_dig_reg;
    logic [2*DIGITS-1:0]   n1_g_next, n1_g_reg;
    stage_ctl_t            n1_ctl_reg;

    always_comb
    begin
        logic [4:0] sum;
        logic       g_prev;
        g_prev      = 1'b0;
        sum         = '0;
        n1_dig_next = '0;
        n1_g_next   = '0;
        for (int p = 0; p < 2*DIGITS; p++)
        begin
            sum = {1'b0, acc_reg[NS-1][4*p +: 4]} + {3'd0, cv_reg[NS-1][2*p +: 2]};
            n1_g_next[p] = g_prev;
            if (sum >= 5'd10)
            begin
                n1_dig_next[4*p +: 4] = 4'(sum - 5'd10);
                g_prev = 1'b1;
            end
            else
            begin
                n1_dig_next[4*p +: 4] = sum[3:0];
                g_prev = 1'b0;
            end
        end
    end

    // Second normalize stage: resolve the one-bit carries.
    logic [PW-1:0] n2_acc_next, n2_acc_reg;
    stage_ctl_t    n2_ctl_reg;

    always_comb
    begin
        logic [4:0] t;
        logic [4:0] u;
        logic       c;
        c           = 1'b0;
        t           = '0;
        u           = '0;
        n2_acc_next = '0;
        for (int p = 0; p < 2*DIGITS; p++)
        begin
            t = {1'b0, n1_dig_reg[4*p +: 4]} + {4'd0, n1_g_reg[p]};
            u = t + {4'd0, c};
            n2_acc_next[4*p +: 4] = (u >= 5'd10) ? 4'(u - 5'd10) : u[3:0];
            c = (t == 5'd10) || (t == 5'd9 && c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[NT-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg[0] <= ctl0;
            a_reg[0]   <= ok0 ? a0 : '0;
            b_reg[0]   <= ok0 ? b0 : '0;
            acc_reg[0] <= '0;
            cv_reg[0]  <= '0;
            cy_reg[0]  <= 1'b0;
            for (int s = 0; s < DIGITS; s++)
            begin
                ctl_reg[s+1] <= ctl_reg[s];
                acc_reg[s+1] <= acc_next[s];
                cv_reg[s+1]  <= cv_next[s];
            end
            for (int s = 0; s < DIGITS - 1; s++)
            begin
                a_reg[s+1]  <= a_reg[s];
                b_reg[s+1]  <= b_reg[s];
                cy_reg[s+1] <= cy_next[s];
            end
            n1_ctl_reg <= ctl_reg[NS-1];
            n1_dig_reg <= n1_dig_next;
            n1_g_reg   <= n1_g_next;
            n2_ctl_reg <= n1_ctl_reg;
            n2_acc_reg <= n2_acc_next;
        end
    end

    // Output stage.
    logic              out_valid_reg;
    logic [FIELD_W-1:0] lo_reg, hi_reg;
    logic [1:0]        st_reg;
    logic [PW-1:0]     fin;

    assign fin = (n2_ctl_reg.status == STAT_OK) ? n2_acc_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= v_reg[NT-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_reg <= FIELD_W'(fin[DW-1:0]);
            hi_reg <= FIELD_W'(fin[PW-1:DW]);
            st_reg <= (n2_ctl_reg.status == STAT_ZERO) ? STAT_OK
                                                       : n2_ctl_reg.status;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = {st_reg, hi_reg, lo_reg};

    // A stalled result must hold its value until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output changed under stall");
    // Input is refused exactly when the output is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("ready mismatch");
    // A refused result carries zero value.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data[2*FIELD_W+1:2*FIELD_W] != STAT_OK
        |-> out_ch.data[2*FIELD_W-1:0] == '0)
        else $error("nonzero value with error status");
endmodule

@@ tb/bcdu_tb_pkg.sv @@
// Decimal arithmetic predictor for the BCD add/subtract/multiply unit testbench.
// Depends on bcdu_pkg for the mode and status codes.
package bcdu_tb_pkg;
    import bcdu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDIG = 10;

    typedef struct packed {
        logic [39:0] lo;
        logic [39:0] hi;
        status_t     st;
    } bcd_answer_t;

    function automatic bcd_answer_t bcd_compute(logic [1:0] op, logic [39:0] a,
                                                logic [39:0] b);
        int unsigned da[NDIG];
        int unsigned db[NDIG];
        int unsigned r[2*NDIG];
        int unsigned c;
        int unsigned m;
        int unsigned borrow;
        int unsigned sub;
        bit ok;
        int cmpv;
        bcd_answer_t ans;
        ans = '0;
        ok = 1'b1;
        cmpv = 0;
        for (int k = 0; k < 2*NDIG; k++) r[k] = 0;
        for (int k = 0; k < NDIG; k++)
        begin
            da[k] = a[4*k +: 4];
            db[k] = b[4*k +: 4];
            if (da[k] > 9 || db[k] > 9) ok = 1'b0;
        end
        if (op == MODE_NOP)
        begin
            return ans;
        end
        if (!ok)
        begin
            ans.st = STAT_INVALID;
            return ans;
        end
        if (op == MODE_ADD)
        begin
            c = 0;
            for (int i = 0; i < NDIG; i++)
            begin
                m = da[i] + db[i] + c;
                c = m / 10;
                r[i] = m % 10;
            end
            r[NDIG] = c;
        end
        else if (op == MODE_SUB)
        begin
            for (int k = NDIG - 1; k >= 0 && cmpv == 0; k--)
            begin
                if (da[k] > db[k]) cmpv = 1;
                else if (da[k] < db[k]) cmpv = -1;
            end
            if (cmpv < 0)
            begin
                ans.st = STAT_NEG;
                return ans;
            end
            borrow = 0;
            for (int i = 0; i < NDIG; i++)
            begin
                sub = db[i] + borrow;
                if (da[i] < sub)
                begin
                    r[i] = da[i] + 10 - sub;
                    borrow = 1;
                end
                else
                begin
                    r[i] = da[i] - sub;
                    borrow = 0;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                c = 0;
                for (int j = 0; j < NDIG; j++)
                begin
                    m = da[i] * db[j] + r[i+j] + c;
                    c = m / 10;
                    r[i+j] = m % 10;
                end
                r[i+NDIG] += c;
            end
        end
        for (int k = 0; k < NDIG; k++)
        begin
            ans.lo[4*k +: 4] = r[k][3:0];
            ans.hi[4*k +: 4] = r[k+NDIG][3:0];
        end
        ans.st = STAT_OK;
        return ans;
    endfunction
endpackage

@@ tb/tb_top.sv @@
// Self-checking testbench top for bcd_add_sub_mul_unit_top.
// Depends on bcdu_pkg, bcdu_stream_if, bcdu_tb_pkg and the RTL top level.
module tb_top;
    import bcdu_pkg::*;
    import bcdu_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W  = 82;
    localparam int OUT_W = 82;
    localparam int N_RANDOM = 1300;
    localparam int LATENCY = NDIG + 3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [39:0] ALL_NINES = 40'h99_9999_9999;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bcdu_stream_if #(.W(IN_W))  in_ch();
    bcdu_stream_if #(.W(OUT_W)) out_ch();

    bcd_add_sub_mul_unit_top #(.DIGITS(NDIG)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // One row of the directed table. When has_exp is set the expected
    // answer is the typed-in one rather than the predictor's.
    typedef struct {
        logic [1:0]  op;
        logic [39:0] a;
        logic [39:0] b;
        bit          has_exp;
        bcd_answer_t exp;
    } stim_row_t;

    bcd_answer_t pending_answers[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;        // last part of the run: no idling on either side
    bit  hold_sink = 1'b0;   // long receiver hold-off requested by the stimulus
    int  sink_hold_len = 0;

    // Random BCD value; sometimes short, sometimes all nines, sometimes with
    // a single bad nibble so that every bit of the field gets exercised.
    function automatic logic [39:0] rand_bcd(bit allow_bad);
        logic [39:0] v;
        int nd;
        v = '0;
        case ($urandom_range(0, 9))
            0: nd = 0;
            1: return ALL_NINES;
            2, 3: nd = $urandom_range(1, 3);
            default: nd = NDIG;
        endcase
        for (int k = 0; k < nd; k++) v[4*k +: 4] = 4'($urandom_range(0, 9));
        if (allow_bad && $urandom_range(0, 9) == 0)
            v[4*$urandom_range(0, NDIG-1) +: 4] = 4'($urandom_range(10, 15));
        return v;
    endfunction

    // The receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold_len) @(posedge clk);
                hold_sink = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result checking against the oldest expected answer.
    always @(posedge clk)
    begin
        bcd_answer_t got;
        bcd_answer_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.lo = out_ch.data[39:0];
            got.hi = out_ch.data[79:40];
            got.st = status_t'(out_ch.data[81:80]);
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result lo=%h hi=%h st=%0d", $time,
                         got.lo, got.hi, got.st);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.lo !== want.lo)
                begin
                    $display("%0t: result_low expected %h actual %h", $time, want.lo, got.lo);
                    errors++;
                end
                if (got.hi !== want.hi)
                begin
                    $display("%0t: result_high expected %h actual %h", $time, want.hi, got.hi);
                    errors++;
                end
                if (got.st !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offers one transfer and waits until it is taken. The expectation is
    // queued at the accepting edge, before the result can come out.
    task automatic send_item(logic [1:0] op, logic [39:0] a, logic [39:0] b,
                             bcd_answer_t ans);
        in_ch.valid <= 1'b1;
        in_ch.data  <= {op, b, a};
        do @(posedge clk); while (!in_ch.ready);
        pending_answers.push_back(ans);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    stim_row_t table_rows[$];

    initial
    begin
        stim_row_t row;
        logic [1:0]  op;
        logic [39:0] a;
        logic [39:0] b;
        bcd_answer_t zero_ans;
        zero_ans = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;

        // Directed table: extremes, every mode, and each special case.
        table_rows.push_back('{MODE_ADD, 40'h0, 40'h0, 1, '{40'h0, 40'h0, STAT_OK}});
        table_rows.push_back('{MODE_ADD, ALL_NINES, ALL_NINES, 1,
                               '{40'h99_9999_9998, 40'h1, STAT_OK}});
        table_rows.push_back('{MODE_ADD, ALL_NINES, 40'h1, 1, '{40'h0, 40'h1, STAT_OK}});
        table_rows.push_back('{MODE_ADD, 40'h12_3456_7890, 40'h98_7654_3210, 0, zero_ans});
        table_rows.push_back('{MODE_SUB, ALL_NINES, ALL_NINES, 1, '{40'h0, 40'h0, STAT_OK}});
        table_rows.push_back('{MODE_SUB, ALL_NINES, 40'h0, 1, '{ALL_NINES, 40'h0, STAT_OK}});
        table_rows.push_back('{MODE_SUB, 40'h0, 40'h1, 1, '{40'h0, 40'h0, STAT_NEG}});
        table_rows.push_back('{MODE_SUB, 40'h10_0000_0000, 40'h1, 0, zero_ans});
        table_rows.push_back('{MODE_SUB, 40'h5, ALL_NINES, 1, '{40'h0, 40'h0, STAT_NEG}});
        table_rows.push_back('{MODE_MUL, ALL_NINES, ALL_NINES, 1,
                               '{40'h1, 40'h99_9999_9998, STAT_OK}});
        table_rows.push_back('{MODE_MUL, ALL_NINES, 40'h0, 1, '{40'h0, 40'h0, STAT_OK}});
        table_rows.push_back('{MODE_MUL, 40'h12_3456_7890, 40'h98_7654_3210, 0, zero_ans});
        table_rows.push_back('{MODE_MUL, 40'h1, ALL_NINES, 1, '{ALL_NINES, 40'h0, STAT_OK}});
        // Invalid digits, checked before the sign of a subtraction.
        table_rows.push_back('{MODE_ADD, 40'hFF_FFFF_FFFF, 40'h0, 1,
                               '{40'h0, 40'h0, STAT_INVALID}});
        table_rows.push_back('{MODE_SUB, 40'h0, 40'hA0_0000_0000, 1,
                               '{40'h0, 40'h0, STAT_INVALID}});
        table_rows.push_back('{MODE_MUL, 40'h1, 40'h0000_000B, 1, '{40'h0, 40'h0, STAT_INVALID}});
        // Unused mode gives all zero even with bad digits.
        table_rows.push_back('{MODE_NOP, ALL_NINES, ALL_NINES, 1, '{40'h0, 40'h0, STAT_OK}});
        table_rows.push_back('{MODE_NOP, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1,
                               '{40'h0, 40'h0, STAT_OK}});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_item(row.op, row.a, row.b,
                      row.has_exp ? row.exp : bcd_compute(row.op, row.a, row.b));
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Long receiver hold-off while the sender keeps offering.
            if (n == 300)
            begin
                sink_hold_len = 60;
                hold_sink = 1'b1;
            end
            // Sender pause until every expected result has arrived.
            if (n == 700)
            begin
                in_ch.valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge clk);
            end
            if (n == N_RANDOM - 150) calm = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? MODE_NOP : 2'($urandom_range(0, 2));
            a = rand_bcd(1'b1);
            b = rand_bcd(1'b1);
            // Bias subtraction toward a valid, non-negative difference.
            if (op == MODE_SUB && $urandom_range(0, 3) != 0 && a < b)
                {a, b} = {b, a};
            send_item(op, a, b, bcd_compute(op, a, b));
        end
        in_ch.valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/bcdu_pkg.sv
rtl/core/bcdu_stream_if.sv
rtl/core/bcd_add_sub_mul_unit_top.sv
tb/bcdu_tb_pkg.sv
tb/tb_top.sv
